// File: rtl/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg: shared definitions for the LRU page fault counter
// Default sizes, register reset values and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfc_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CAP_BITS      = 5;
  localparam int COUNT_BITS    = 32;

  localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic step;   // an item is accepted this cycle
    logic hit;    // the reference matched a valid entry
    logic clear;  // the item ends its sequence
  } lpfc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lpfc_cell.sv
// ----------------------------------------------------------------------------
// lpfc_cell: one recency slot of the LRU list
// Holds a tag and a valid bit, compares against the reference and takes its
// neighbor's entry when the list moves down.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfc_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = lpfc_pkg::PAGE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lpfc_pkg::lpfc_ctrl_t          ctrl_i,
  input  wire logic [lpfc_pkg::CAP_BITS-1:0] cap_i,
  input  wire logic [PAGE_BITS-1:0]          ref_tag_i,
  input  wire logic [PAGE_BITS-1:0]          prev_tag_i,
  input  wire logic                          prev_valid_i,
  input  wire logic                          seen_i,
  output logic                               seen_o,
  output logic [PAGE_BITS-1:0]               tag_o,
  output logic                               valid_o
);

  import lpfc_pkg::*;

  logic [PAGE_BITS-1:0] tag_r, tag_nxt;
  logic                 valid_r, valid_nxt;
  logic                 match;
  logic                 keep;

  assign match  = valid_r && (tag_r == ref_tag_i);
  // a match here or further down the list: this slot lies at or above the hit
  assign seen_o = match | seen_i;
  assign keep   = int'(cap_i) > IDX;

  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    if (ctrl_i.step) begin
      if (ctrl_i.hit) begin
        if (seen_o) begin
          tag_nxt = prev_tag_i;
        end
      end else begin
        tag_nxt   = prev_tag_i;
        valid_nxt = prev_valid_i && keep;
      end
      if (ctrl_i.clear) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign tag_o   = tag_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

// File: rtl/lru_page_fault_counter.sv
// ----------------------------------------------------------------------------
// lru_page_fault_counter: LRU page replacement with a fault counter
// Keeps resident pages in recency order in a chain of cells and reports,
// for every referenced page, a fault flag and the running fault count.
// ----------------------------------------------------------------------------
// The result strobes on out_valid in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since the whole compare,
//   shift and count update of an item settles in the cycle it is accepted
//   (the slowest path is the hit ripple through the DEPTH cells).
// Results cannot be stalled: each is shown for exactly one cycle.
// Reset (rst_n low, synchronous): list empty, count zero, capacity 16.
`default_nettype none

module lru_page_fault_counter #(
  parameter int DEPTH     = lpfc_pkg::DEPTH_DEF,
  parameter int PAGE_BITS = lpfc_pkg::PAGE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [PAGE_BITS-1:0]            in_page,
  input  wire logic                            in_last_page,
  // results
  output logic                                 out_valid,
  output logic                                 out_fault,
  output logic [lpfc_pkg::COUNT_BITS-1:0]      out_fault_count,
  // capacity register
  input  wire logic                            cfg_we,
  input  wire logic [lpfc_pkg::CAP_BITS-1:0]   cfg_data
);

  import lpfc_pkg::*;

  logic                  accept;
  lpfc_ctrl_t            ctrl;

  logic [CAP_BITS-1:0]   cap_r, cap_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] total_upd;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_fault_r, out_fault_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;

  logic [PAGE_BITS-1:0]  tag_chain   [DEPTH];
  logic                  valid_chain [DEPTH];
  logic [DEPTH:0]        seen;

  // Every item completes in its accept cycle: never hold off the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ctrl.step  = accept;
  assign ctrl.hit   = seen[0];
  assign ctrl.clear = in_last_page;

  // Tail of the hit ripple: nothing lies past the last cell.
  assign seen[DEPTH] = 1'b0;

  // Cell 0 takes the referenced page itself; every other cell takes the
  // entry of the cell above it when the list moves down.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PAGE_BITS-1:0] prev_tag;
    logic                 prev_valid;

    if (i == 0) begin : g_head
      assign prev_tag   = in_page;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_tag   = tag_chain[i-1];
      assign prev_valid = valid_chain[i-1];
    end

    lpfc_cell #(
      .IDX       (i),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .cap_i        (cap_r),
      .ref_tag_i    (in_page),
      .prev_tag_i   (prev_tag),
      .prev_valid_i (prev_valid),
      .seen_i       (seen[i+1]),
      .seen_o       (seen[i]),
      .tag_o        (tag_chain[i]),
      .valid_o      (valid_chain[i])
    );
  end

  // Count the fault, holding at the top value.
  always_comb begin
    total_upd = total_r;
    if (!seen[0] && (total_r != COUNT_MAX)) begin
      total_upd = total_r + COUNT_BITS'(1);
    end
  end

  always_comb begin
    cap_nxt       = cap_r;
    total_nxt     = total_r;
    out_valid_nxt = accept;
    out_fault_nxt = out_fault_r;
    out_count_nxt = out_count_r;
    if (cfg_we) begin
      cap_nxt = cfg_data;
    end
    if (accept) begin
      out_fault_nxt = !seen[0];
      out_count_nxt = total_upd;
      // a last item reports normally, then the sequence starts over
      total_nxt     = in_last_page ? '0 : total_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: no reset, qualified by the strobe.
  always_ff @(posedge clk) begin
    out_fault_r <= out_fault_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_fault       = out_fault_r;
  assign out_fault_count = out_count_r;

endmodule

`default_nettype wire

// File: test/lru_page_fault_counter_test.sv
// ----------------------------------------------------------------------------
// lru_page_fault_counter_test: self-checking bench for the LRU fault counter
// Drives page references through the command port and rebuilds the recency
// list and fault count in the bench. Each result strobe is checked against the
// oldest prediction. Capacity is swept over zero, one, the full depth and
// values above it, and the sender runs at several idle rates.
// ----------------------------------------------------------------------------
module lru_page_fault_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfc_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PAGE_BITS   = PAGE_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // One expected result: hit-or-fault flag and the running count.
  typedef struct packed {
    logic                  fault;
    logic [COUNT_BITS-1:0] count;
  } page_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [PAGE_BITS-1:0]  in_page;
  logic                  in_last_page;
  logic                  out_valid;
  logic                  out_fault;
  logic [COUNT_BITS-1:0] out_fault_count;
  logic                  cfg_we;
  logic [CAP_BITS-1:0]   cfg_data;

  // Bench copy of the block state, advanced at every accepted item.
  logic [PAGE_BITS-1:0]  lru_list [DEPTH];
  int                    resident;
  logic [COUNT_BITS-1:0] fault_total;
  logic [CAP_BITS-1:0]   frames_reg;

  page_result_t          pending_results [$];
  page_result_t          want;
  page_result_t          got;

  int          sender_idle;
  int          error_count;
  int          refs_accepted;
  int          results_checked;
  int          faults_seen;
  int          cycle_count;
  logic [31:0] frames_used;

  lru_page_fault_counter #(
    .DEPTH    (DEPTH),
    .PAGE_BITS(PAGE_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_page        (in_page),
    .in_last_page   (in_last_page),
    .out_valid      (out_valid),
    .out_fault      (out_fault),
    .out_fault_count(out_fault_count),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Look the page up, move or insert it at the front, trim to the usable
  // frames on a miss, and bump the saturating count. A last item clears the
  // list and the count after its result is formed.
  function automatic page_result_t predict_ref(input logic [PAGE_BITS-1:0] pg,
                                               input logic lst);
    page_result_t res;
    int           pos;
    int           grown;
    int           frames;
    bit           hit;
    frames = (frames_reg > DEPTH) ? DEPTH : int'(frames_reg);
    hit    = 1'b0;
    pos    = 0;
    for (int i = 0; i < resident; i++) begin
      if (!hit && lru_list[i] == pg) begin
        hit = 1'b1;
        pos = i;
      end
    end
    if (hit) begin
      for (int i = pos; i > 0; i--) lru_list[i] = lru_list[i-1];
      lru_list[0] = pg;
    end else begin
      if (fault_total != COUNT_MAX) fault_total++;
      grown = (resident + 1 > DEPTH) ? DEPTH : resident + 1;
      for (int i = grown - 1; i > 0; i--) lru_list[i] = lru_list[i-1];
      lru_list[0] = pg;
      resident = (grown > frames) ? frames : grown;
    end
    res.fault = !hit;
    res.count = fault_total;
    if (lst) begin
      resident    = 0;
      fault_total = '0;
    end
    return res;
  endfunction

  // Check the strobed result first, then predict for an item taken at this
  // edge, then latch a capacity write. Results come from a register behind their
  // item, so this order never pairs a result with its own item.
  always @(posedge clk) begin
    if (!rst_n) begin
      resident    = 0;
      fault_total = '0;
      frames_reg  = CAP_RESET;
      pending_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        got.fault = out_fault;
        got.count = out_fault_count;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual fault=%b count=%0d",
                   $time, got.fault, got.count);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.fault !== want.fault) begin
            error_count++;
            $display("%0t: fault flag mismatch, expected %b actual %b", $time,
                     want.fault, got.fault);
          end
          if (got.count !== want.count) begin
            error_count++;
            $display("%0t: fault count mismatch, expected %0d actual %0d", $time,
                     want.count, got.count);
          end
        end
      end
      if (start && busy === 1'b0) begin
        want = predict_ref(in_page, in_last_page);
        pending_results.push_back(want);
        refs_accepted++;
        if (want.fault) faults_seen++;
      end
      if (cfg_we) frames_reg = cfg_data;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item at the falling edge and hold it until taken. Drop start
  // only while idling, so back-to-back items keep it high.
  task automatic send_ref(input logic [PAGE_BITS-1:0] pg, input logic lst);
    while ($urandom_range(0, 99) < sender_idle) begin
      start        = 1'b0;
      in_page      = PAGE_BITS'($urandom);
      in_last_page = 1'($urandom);
      @(negedge clk);
    end
    start        = 1'b1;
    in_page      = pg;
    in_last_page = lst;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write the capacity register only with the block idle.
  task automatic set_frames(input logic [CAP_BITS-1:0] frames);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_data = frames;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = CAP_BITS'($urandom);
    frames_used[frames] = 1'b1;
  endtask

  // Extreme page numbers at the reset capacity; the last two hit.
  task automatic test_page_extremes();
    frames_used[CAP_RESET] = 1'b1;
    send_ref('0, 1'b0);
    send_ref('1, 1'b0);
    send_ref('0, 1'b0);
    send_ref('1, 1'b1);
  endtask

  // Fill four frames, refresh the oldest, then force three evictions of the
  // least recent page.
  task automatic test_eviction_order();
    set_frames(CAP_BITS'(4));
    send_ref(PAGE_BITS'(1), 1'b0);
    send_ref(PAGE_BITS'(2), 1'b0);
    send_ref(PAGE_BITS'(3), 1'b0);
    send_ref(PAGE_BITS'(4), 1'b0);
    send_ref(PAGE_BITS'(1), 1'b0);
    send_ref(PAGE_BITS'(5), 1'b0);
    send_ref(PAGE_BITS'(2), 1'b0);
    send_ref(PAGE_BITS'(3), 1'b1);
  endtask

  // Zero frames: the same page faults twice. One frame: a repeat hits and
  // any other page evicts it. Capacity above depth acts as the full depth.
  task automatic test_frame_extremes();
    set_frames('0);
    send_ref(PAGE_BITS'(16'h00a5), 1'b0);
    send_ref(PAGE_BITS'(16'h00a5), 1'b1);
    set_frames(CAP_BITS'(1));
    send_ref(PAGE_BITS'(16'h0033), 1'b0);
    send_ref(PAGE_BITS'(16'h0033), 1'b0);
    send_ref(PAGE_BITS'(16'h0044), 1'b0);
    send_ref(PAGE_BITS'(16'h0033), 1'b1);
    set_frames('1);
    send_ref(PAGE_BITS'(16'h5a5a), 1'b0);
    send_ref(PAGE_BITS'(16'ha5a5), 1'b0);
    send_ref(PAGE_BITS'(16'h5a5a), 1'b1);
  endtask

  // Shrink capacity in the middle of a sequence: a deep entry still hits,
  // and the next miss trims the list to the new size.
  task automatic test_shrink_midsequence();
    set_frames(CAP_BITS'(16));
    for (int i = 0; i < 5; i++) send_ref(PAGE_BITS'(16'h0100 + i), 1'b0);
    set_frames(CAP_BITS'(2));
    send_ref(PAGE_BITS'(16'h0100), 1'b0);
    send_ref(PAGE_BITS'(16'h0105), 1'b0);
    send_ref(PAGE_BITS'(16'h0101), 1'b1);
  endtask

  // Random sequences drawn from a small page pool so hits and evictions both
  // happen, with some noise pages and early sequence ends. Capacity changes
  // every 45 items, often mid-sequence, after a full drain.
  task automatic test_random_refs(input int idle_pct, input int n_items);
    logic [PAGE_BITS-1:0] pool [24];
    logic [PAGE_BITS-1:0] pg;
    logic                 lst;
    int                   seq_left;
    int                   pool_sz;
    int                   pick;
    sender_idle = idle_pct;
    seq_left    = 0;
    pool_sz     = 1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 45 == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      set_frames('0);
        else if (pick == 1) set_frames(CAP_BITS'($urandom_range(17, 31)));
        else                set_frames(CAP_BITS'($urandom_range(1, 16)));
      end
      if (seq_left == 0) begin
        seq_left = $urandom_range(1, 60);
        pool_sz  = $urandom_range(1, 24);
        for (int i = 0; i < pool_sz; i++) pool[i] = PAGE_BITS'($urandom);
      end
      if ($urandom_range(0, 99) < 12) pg = PAGE_BITS'($urandom);
      else                            pg = pool[$urandom_range(0, pool_sz - 1)];
      seq_left--;
      lst = (seq_left == 0) || ($urandom_range(0, 99) < 2);
      if (lst) seq_left = 0;
      send_ref(pg, lst);
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_page         = '0;
    in_last_page    = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    sender_idle     = 0;
    error_count     = 0;
    refs_accepted   = 0;
    results_checked = 0;
    faults_seen     = 0;
    cycle_count     = 0;
    frames_used     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    sender_idle = 19;
    test_page_extremes();
    test_eviction_order();
    test_frame_extremes();
    test_shrink_midsequence();
    test_random_refs(19, 135);
    test_random_refs(85, 135);
    test_random_refs(0, 135);

    // Let any stray strobe show up before the verdict.
    wait_drained();
    repeat (4) @(negedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time,
               pending_results.size());
    end
    $display("Checked %0d results for %0d references, %0d of them faults,",
             results_checked, refs_accepted, faults_seen);
    $display("over %0d capacity settings and sender idle rates of 19, 85 and 0 percent.",
             $countones(frames_used));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: lru_page_fault_counter.f
rtl/lpfc_pkg.sv
rtl/lpfc_cell.sv
rtl/lru_page_fault_counter.sv
test/lru_page_fault_counter_test.sv
